>>> design/rscd_pkg.sv
// ============================================================================
// rscd_pkg - shared types for the ray/segment closest distance block
// Payload structs, segment parameter codes and fixed constants.
// ============================================================================
`default_nettype none

package rscd_pkg;

    // One query: ray origin and direction, segment ends, all signed Q16.16.
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] direction_x;
        logic signed [31:0] direction_y;
        logic signed [31:0] direction_z;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } t_in;

    // One answer: distance (unsigned Q16.16), ray parameter, clamped segment parameter.
    typedef struct packed {
        logic        [31:0] distance;
        logic signed [31:0] ray_param;
        logic        [16:0] segment_param;
    } t_out;

    // How the segment parameter is formed.
    typedef enum logic [1:0] {
        TC_DIV  = 2'd0,
        TC_ZERO = 2'd1,
        TC_ONE  = 2'd2
    } t_tcode;

    localparam logic [31:0] THR_RESET  = 32'd42950;
    localparam logic [16:0] T_ONE_Q16  = 17'h10000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;

endpackage

`default_nettype wire

>>> design/rscd_dly.sv
// ============================================================================
// rscd_dly - enabled delay line
// Carries side data alongside the pipelined arithmetic for N stages.
// ============================================================================
`default_nettype none

module rscd_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);

    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[N-1];

endmodule

`default_nettype wire

>>> design/rscd_mul.sv
// ============================================================================
// rscd_mul - two-stage wide signed multiplier
// Splits each operand into halves; four partial products, then one sum.
// ============================================================================
`default_nettype none

module rscd_mul #(
    parameter int W = 68
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [W-1:0]   i_a,
    input  wire logic signed [W-1:0]   i_b,
    output logic signed      [2*W-1:0] o_p
);

    localparam int H  = W / 2;
    localparam int HU = W - H;
    localparam int PW = W + 2;

    logic signed [PW-1:0] a_lo, a_hi, b_lo, b_hi;
    logic signed [PW-1:0] r_ll, r_lh, r_hl, r_hh;
    logic signed [2*W-1:0] r_p;
    logic [2*W-1:0] e_ll, e_lh, e_hl, e_hh;

    // Low halves are unsigned, high halves carry the sign.
    assign a_lo = {{(PW-H){1'b0}}, i_a[H-1:0]};
    assign b_lo = {{(PW-H){1'b0}}, i_b[H-1:0]};
    assign a_hi = {{(PW-HU){i_a[W-1]}}, i_a[W-1:H]};
    assign b_hi = {{(PW-HU){i_b[W-1]}}, i_b[W-1:H]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= a_lo * b_lo;
            r_lh <= a_lo * b_hi;
            r_hl <= a_hi * b_lo;
            r_hh <= a_hi * b_hi;
        end
    end

    assign e_ll = {{(2*W-PW){r_ll[PW-1]}}, r_ll};
    assign e_lh = {{(2*W-PW){r_lh[PW-1]}}, r_lh};
    assign e_hl = {{(2*W-PW){r_hl[PW-1]}}, r_hl};
    assign e_hh = {{(2*W-PW){r_hh[PW-1]}}, r_hh};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= $signed((e_hh << (2*H)) + ((e_lh + e_hl) << H) + e_ll);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> design/rscd_dot.sv
// ============================================================================
// rscd_dot - difference vectors and the five dot products
// Three stages: differences, products, sums.
// ============================================================================
`default_nettype none

module rscd_dot (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire rscd_pkg::t_in        i_data,
    output logic signed [67:0]        o_a,
    output logic signed [67:0]        o_b,
    output logic signed [67:0]        o_c,
    output logic signed [67:0]        o_d,
    output logic signed [67:0]        o_e,
    output logic [2:0][32:0]          o_dv,
    output logic [2:0][32:0]          o_sv,
    output logic [2:0][32:0]          o_wv
);
    import rscd_pkg::*;

    function automatic logic signed [65:0] mul33(input logic signed [32:0] x,
                                                 input logic signed [32:0] y);
        logic signed [65:0] xe, ye;
        xe = {{33{x[32]}}, x};
        ye = {{33{y[32]}}, y};
        return xe * ye;
    endfunction

    function automatic logic signed [67:0] sum3(input logic signed [65:0] p0,
                                                input logic signed [65:0] p1,
                                                input logic signed [65:0] p2);
        return {{2{p0[65]}}, p0} + {{2{p1[65]}}, p1} + {{2{p2[65]}}, p2};
    endfunction

    logic [2:0][31:0] org, dir, sta, fin;
    logic [2:0][32:0] r1_dv, r1_sv, r1_wv, r2_dv, r2_sv, r2_wv, r3_dv, r3_sv, r3_wv;
    logic signed [65:0] r2_dd [3], r2_ds [3], r2_ss [3], r2_dw [3], r2_sw [3];
    logic signed [67:0] r3_a, r3_b, r3_c, r3_d, r3_e;

    assign org = {i_data.origin_x, i_data.origin_y, i_data.origin_z};
    assign dir = {i_data.direction_x, i_data.direction_y, i_data.direction_z};
    assign sta = {i_data.start_x, i_data.start_y, i_data.start_z};
    assign fin = {i_data.end_x, i_data.end_y, i_data.end_z};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_dv[k] <= {dir[k][31], dir[k]};
                r1_sv[k] <= {fin[k][31], fin[k]} - {sta[k][31], sta[k]};
                r1_wv[k] <= {org[k][31], org[k]} - {sta[k][31], sta[k]};
            end
            for (int k = 0; k < 3; k++) begin
                r2_dd[k] <= mul33(r1_dv[k], r1_dv[k]);
                r2_ds[k] <= mul33(r1_dv[k], r1_sv[k]);
                r2_ss[k] <= mul33(r1_sv[k], r1_sv[k]);
                r2_dw[k] <= mul33(r1_dv[k], r1_wv[k]);
                r2_sw[k] <= mul33(r1_sv[k], r1_wv[k]);
            end
            r2_dv <= r1_dv;
            r2_sv <= r1_sv;
            r2_wv <= r1_wv;
            r3_a  <= sum3(r2_dd[0], r2_dd[1], r2_dd[2]);
            r3_b  <= sum3(r2_ds[0], r2_ds[1], r2_ds[2]);
            r3_c  <= sum3(r2_ss[0], r2_ss[1], r2_ss[2]);
            r3_d  <= sum3(r2_dw[0], r2_dw[1], r2_dw[2]);
            r3_e  <= sum3(r2_sw[0], r2_sw[1], r2_sw[2]);
            r3_dv <= r2_dv;
            r3_sv <= r2_sv;
            r3_wv <= r2_wv;
        end
    end

    assign o_a  = r3_a;
    assign o_b  = r3_b;
    assign o_c  = r3_c;
    assign o_d  = r3_d;
    assign o_e  = r3_e;
    assign o_dv = r3_dv;
    assign o_sv = r3_sv;
    assign o_wv = r3_wv;

endmodule

`default_nettype wire

>>> design/rscd_div.sv
// ============================================================================
// rscd_div - pipelined restoring divider
// One quotient bit per stage; the numerator must be below den << QB.
// ============================================================================
`default_nettype none

module rscd_div #(
    parameter int DW = 136,
    parameter int QB = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DW+QB-1:0]  i_n,
    input  wire logic [DW-1:0]     i_d,
    output logic      [QB-1:0]     o_q
);

    localparam int RW = DW + QB;

    logic [RW-1:0] r_rem [QB-1];
    logic [DW-1:0] r_d   [QB-1];
    logic [QB-1:0] r_q   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_st
        localparam int I = QB - 1 - k;
        logic [RW-1:0] rem_in, trial;
        logic [DW-1:0] d_in;
        logic [QB-1:0] q_in, q_nx;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = i_n;
            assign d_in   = i_d;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign d_in   = r_d[k-1];
            assign q_in   = r_q[k-1];
        end

        assign trial = {{QB{1'b0}}, d_in} << I;
        assign ge    = (rem_in >= trial);

        always_comb begin
            q_nx    = q_in;
            q_nx[I] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k] <= q_nx;
            end
        end

        if (k < QB - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? (rem_in - trial) : rem_in;
                    r_d[k]   <= d_in;
                end
            end
        end
    end

    assign o_q = r_q[QB-1];

endmodule

`default_nettype wire

>>> design/rscd_sqrt.sv
// ============================================================================
// rscd_sqrt - pipelined integer square root
// One root bit per stage, keeping the remainder y - root^2.
// ============================================================================
`default_nettype none

module rscd_sqrt #(
    parameter int YW = 98,
    parameter int RB = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [YW-1:0] i_y,
    output logic      [RB-1:0] o_root
);

    localparam int TW = (YW > 2 * RB + 1) ? YW : 2 * RB + 1;

    logic [TW-1:0] r_rem  [RB-1];
    logic [RB-1:0] r_root [RB];

    for (genvar k = 0; k < RB; k++) begin : g_st
        localparam int I = RB - 1 - k;
        logic [TW-1:0] rem_in, trial;
        logic [RB-1:0] root_in, root_nx;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = TW'(i_y);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // (root + 2^I)^2 - root^2, the lower root bits being still zero.
        assign trial = (TW'(root_in) << (I + 1)) | (TW'(1) << (2 * I));
        assign ge    = (rem_in >= trial);

        always_comb begin
            root_nx    = root_in;
            root_nx[I] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= root_nx;
            end
        end

        if (k < RB - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule

`default_nettype wire

>>> design/ray_segment_closest_distance_top.sv
// ============================================================================
// ray_segment_closest_distance_top - line to segment closest approach
// Fully pipelined: one query per cycle in, one answer per cycle out, while the receiver does not stall.
// ============================================================================
//
// The input channel carries one query per transaction: a ray origin and
// direction and the two segment ends, all signed Q16.16. The output channel
// returns one transaction per query, in order: the distance between the two
// closest points, the ray parameter s (unclamped, saturated) and the segment
// parameter t clamped to [0, 1].
// Both channels use valid and stall. A transaction moves at a clock edge with
// valid high and stall low. The configuration channel (valid/ready, always
// ready) writes the parallel threshold; the user must write it only while
// the block is empty, as the block itself does not enforce it.
// The pipeline depth is set by the two pipelined dividers (33 stages for s)
// and the square root (one stage per root bit). Throughput is one
// transaction per cycle while the receiver does not stall.
// A synchronous active-low reset empties the pipeline and restores the
// threshold. When the receiver stalls a valid result, the whole pipeline
// holds and the input channel stalls in the same cycle; nothing is lost.
//
`default_nettype none

module ray_segment_closest_distance_top #(
    parameter int SQRT_ITERATIONS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire rscd_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output rscd_pkg::t_out      o_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [31:0]    i_cfg_data
);
    import rscd_pkg::*;

    localparam int RB  = SQRT_ITERATIONS;
    localparam int LAT = 49 + RB;
    localparam int SQB = 33;
    localparam int TQB = 16;

    // Pipeline control: every stage advances together. The output register
    // is the last stage; the pipe moves whenever it is empty or being taken.
    logic           en;
    logic [LAT:1]   r_vld;
    logic [31:0]    r_thr;

    assign en          = !r_vld[LAT] || !i_stall;
    assign o_stall     = !en;
    assign o_valid     = r_vld[LAT];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // Stages 1 to 3: difference vectors and dot products.
    logic signed [67:0] a3, b3, c3, d3, e3;
    logic [2:0][32:0]   dv3, sv3, wv3;

    rscd_dot u_dot (
        .i_clk (i_clk), .i_en (en), .i_data (i_data),
        .o_a (a3), .o_b (b3), .o_c (c3), .o_d (d3), .o_e (e3),
        .o_dv (dv3), .o_sv (sv3), .o_wv (wv3)
    );

    // Stages 4 and 5: the six products of dot products.
    logic signed [135:0] ac5, bb5, be5, cd5, ae5, bd5;
    logic [67:0]         c5, e5;

    rscd_mul #(.W(68)) u_mul_ac (.i_clk(i_clk), .i_en(en), .i_a(a3), .i_b(c3), .o_p(ac5));
    rscd_mul #(.W(68)) u_mul_bb (.i_clk(i_clk), .i_en(en), .i_a(b3), .i_b(b3), .o_p(bb5));
    rscd_mul #(.W(68)) u_mul_be (.i_clk(i_clk), .i_en(en), .i_a(b3), .i_b(e3), .o_p(be5));
    rscd_mul #(.W(68)) u_mul_cd (.i_clk(i_clk), .i_en(en), .i_a(c3), .i_b(d3), .o_p(cd5));
    rscd_mul #(.W(68)) u_mul_ae (.i_clk(i_clk), .i_en(en), .i_a(a3), .i_b(e3), .o_p(ae5));
    rscd_mul #(.W(68)) u_mul_bd (.i_clk(i_clk), .i_en(en), .i_a(b3), .i_b(d3), .o_p(bd5));

    rscd_dly #(.W(136), .N(2)) u_dly_ce (
        .i_clk (i_clk), .i_en (en), .i_d ({c3, e3}), .o_q ({c5, e5})
    );

    // Stage 6: determinant and the two numerators. The determinant is never
    // negative (Cauchy-Schwarz), so its low 136 bits are its magnitude.
    logic signed [136:0] r6_det, r6_sn, r6_tn;
    logic signed [67:0]  r6_c, r6_e;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_det <= {ac5[135], ac5} - {bb5[135], bb5};
            r6_sn  <= {be5[135], be5} - {cd5[135], cd5};
            r6_tn  <= {ae5[135], ae5} - {bd5[135], bd5};
            r6_c   <= $signed(c5);
            r6_e   <= $signed(e5);
        end
    end

    // Stage 7: parallel test, and the clamping codes for both candidate
    // ratios of t (e over c, or the closed form over det).
    logic                r7_par;
    t_tcode              r7_codea, r7_codeb;
    logic [135:0]        r7_det;
    logic signed [136:0] r7_sn, r7_tn;
    logic signed [67:0]  r7_c, r7_e;
    t_tcode              codea, codeb;

    always_comb begin
        if (r6_c == '0) begin
            codea = TC_ONE;
        end else if (r6_e <= 0) begin
            codea = TC_ZERO;
        end else if (r6_e >= r6_c) begin
            codea = TC_ONE;
        end else begin
            codea = TC_DIV;
        end
        if (r6_det == '0) begin
            codeb = TC_ONE;
        end else if (r6_tn <= 0) begin
            codeb = TC_ZERO;
        end else if (r6_tn >= r6_det) begin
            codeb = TC_ONE;
        end else begin
            codeb = TC_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_par   <= (r6_det == '0) ||
                        (r6_det < $signed({73'd0, r_thr, 32'd0}));
            r7_codea <= codea;
            r7_codeb <= codeb;
            r7_det   <= r6_det[135:0];
            r7_sn    <= r6_sn;
            r7_tn    <= r6_tn;
            r7_c     <= r6_c;
            r7_e     <= r6_e;
        end
    end

    // Stage 8: pick the t ratio; take the magnitude of the s numerator.
    logic [135:0] r8_tnum, r8_tden, r8_det;
    t_tcode       r8_tcode;
    logic [152:0] r8_sn;
    logic         r8_sneg, r8_par;
    logic [136:0] sn_mag;

    assign sn_mag = r7_sn[136] ? $unsigned(-r7_sn) : $unsigned(r7_sn);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r7_par) begin
                r8_tnum  <= {{68{r7_e[67]}}, r7_e};
                r8_tden  <= {{68{r7_c[67]}}, r7_c};
                r8_tcode <= r7_codea;
            end else begin
                r8_tnum  <= r7_tn[135:0];
                r8_tden  <= r7_det;
                r8_tcode <= r7_codeb;
            end
            r8_sn   <= {sn_mag, 16'd0};
            r8_sneg <= r7_sn[136];
            r8_par  <= r7_par;
            r8_det  <= r7_det;
        end
    end

    // Stage 9: saturation test for s (quotient of 2^33 or more).
    logic [168:0] r9_n;
    logic [135:0] r9_det;
    logic         r9_ovf, r9_sneg, r9_par;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_n    <= {16'd0, r8_sn};
            r9_ovf  <= {16'd0, r8_sn} >= {r8_det, 33'd0};
            r9_det  <= r8_det;
            r9_sneg <= r8_sneg;
            r9_par  <= r8_par;
        end
    end

    // Stages 10 to 42 divide for s; stages 9 to 24 divide for t.
    logic [SQB-1:0] sq42;
    logic [TQB-1:0] tq24, tq42;
    logic           ovf42, sneg42, par42;
    logic [1:0]     tcode42;

    rscd_div #(.DW(136), .QB(SQB)) u_div_s (
        .i_clk (i_clk), .i_en (en), .i_n (r9_n), .i_d (r9_det), .o_q (sq42)
    );

    rscd_div #(.DW(136), .QB(TQB)) u_div_t (
        .i_clk (i_clk), .i_en (en), .i_n ({r8_tnum, 16'd0}), .i_d (r8_tden), .o_q (tq24)
    );

    rscd_dly #(.W(3), .N(SQB)) u_dly_sflags (
        .i_clk (i_clk), .i_en (en), .i_d ({r9_ovf, r9_sneg, r9_par}),
        .o_q ({ovf42, sneg42, par42})
    );

    rscd_dly #(.W(TQB), .N(18)) u_dly_tq (
        .i_clk (i_clk), .i_en (en), .i_d (tq24), .o_q (tq42)
    );

    rscd_dly #(.W(2), .N(34)) u_dly_tcode (
        .i_clk (i_clk), .i_en (en), .i_d (r8_tcode), .o_q (tcode42)
    );

    // Stage 43: saturated s and clamped t.
    logic signed [31:0] r43_s;
    logic [16:0]        r43_t;
    logic [2:0][32:0]   dv43, sv43, wv43;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (par42) begin
                r43_s <= '0;
            end else if (sneg42) begin
                if (ovf42 || (sq42 > {1'b0, S_MIN})) begin
                    r43_s <= S_MIN;
                end else begin
                    r43_s <= $signed(-sq42[31:0]);
                end
            end else begin
                if (ovf42 || (sq42 > {1'b0, S_MAX})) begin
                    r43_s <= S_MAX;
                end else begin
                    r43_s <= $signed(sq42[31:0]);
                end
            end
            case (t_tcode'(tcode42))
                TC_DIV:  r43_t <= {1'b0, tq42};
                TC_ZERO: r43_t <= '0;
                TC_ONE:  r43_t <= T_ONE_Q16;
                default: r43_t <= '0;
            endcase
        end
    end

    rscd_dly #(.W(297), .N(40)) u_dly_vec (
        .i_clk (i_clk), .i_en (en), .i_d ({dv3, sv3, wv3}), .o_q ({dv43, sv43, wv43})
    );

    // Stages 44 and 45: the difference vector between the closest points,
    // with 32 fraction bits. Both products fit in 64 bits.
    function automatic logic signed [63:0] mul64(input logic signed [32:0] x,
                                                 input logic signed [32:0] y);
        logic signed [65:0] p;
        p = x * y;
        return p[63:0];
    endfunction

    logic signed [63:0] r44_ds [3], r44_st [3], r44_w [3];
    logic signed [63:0] r45_comp [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r44_ds[k] <= mul64(dv43[k], {r43_s[31], r43_s});
                r44_st[k] <= mul64(sv43[k], {16'd0, r43_t});
                r44_w[k]  <= {{15{wv43[k][32]}}, wv43[k], 16'd0};
            end
            for (int k = 0; k < 3; k++) begin
                r45_comp[k] <= r44_w[k] + r44_ds[k] - r44_st[k];
            end
        end
    end

    // Stages 46 and 47: squares. Stage 48: sum and drop 32 fraction bits.
    logic signed [127:0] sq47 [3];
    logic [97:0]         r48_y;
    logic [129:0]        sumsq;

    for (genvar k = 0; k < 3; k++) begin : g_sq
        rscd_mul #(.W(64)) u_mul_sq (
            .i_clk (i_clk), .i_en (en), .i_a (r45_comp[k]), .i_b (r45_comp[k]),
            .o_p (sq47[k])
        );
    end

    assign sumsq = {2'b00, sq47[0]} + {2'b00, sq47[1]} + {2'b00, sq47[2]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r48_y <= sumsq[129:32];
        end
    end

    // Stages 49 to 48 + RB: square root, one bit per stage.
    logic [RB-1:0]      root;
    logic signed [31:0] s_last;
    logic [16:0]        t_last;
    logic [31:0]        dist_sat;
    t_out               r_out;

    rscd_sqrt #(.YW(98), .RB(RB)) u_sqrt (
        .i_clk (i_clk), .i_en (en), .i_y (r48_y), .o_root (root)
    );

    rscd_dly #(.W(49), .N(5 + RB)) u_dly_st (
        .i_clk (i_clk), .i_en (en), .i_d ({r43_s, r43_t}), .o_q ({s_last, t_last})
    );

    if (RB > 32) begin : g_sat
        assign dist_sat = (|root[RB-1:32]) ? '1 : root[31:0];
    end else begin : g_nosat
        assign dist_sat = 32'(root);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.distance      <= dist_sat;
            r_out.ray_param     <= s_last;
            r_out.segment_param <= t_last;
        end
    end

    assign o_data = r_out;

    // Reset empties the pipeline, including the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // The clamped segment parameter never exceeds 1.0.
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.segment_param <= T_ONE_Q16))
        else $error("segment parameter above 1.0");

    // A taken result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_vld[LAT-1]) |=> !o_valid)
        else $error("result repeated");

endmodule

`default_nettype wire
